/* rtl/task_wait_queue_unit_defines.svh */
// Assertion macros for the task wait queue unit
`ifndef TASK_WAIT_QUEUE_UNIT_DEFINES_SVH
`define TASK_WAIT_QUEUE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define TWQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold on the clock edge after a trigger
`define TWQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/twq_pkg.sv */
// Types and constants shared by the task wait queue modules
package twq_pkg;
    localparam int Depth = 16;
    localparam int IdxW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_SORTED = 3'd1;
    localparam logic [2:0] FN_POP    = 3'd2;
    localparam logic [2:0] FN_REMOVE = 3'd3;
    localparam logic [2:0] FN_ROTATE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic latch;    // capture operation
        logic execute;  // apply the decided operation
    } t_twq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic dummy_ready;
    } t_twq_sts;
endpackage

/* rtl/twq_ctrl.sv */
// Sequencing controller for the task wait queue
module twq_ctrl import twq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_twq_sts i_sts,
    output logic     busy,
    output t_twq_cmd o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Next state: compare cycle, then execute cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start && i_sts.dummy_ready) n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign busy          = (r_state == S_EXEC);
    assign o_cmd.latch   = (r_state == S_IDLE) && start;
    assign o_cmd.execute = (r_state == S_EXEC);
endmodule

/* rtl/twq_dp.sv */
// Shifting cell array datapath for the task wait queue
module twq_dp import twq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_twq_cmd    i_cmd,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_wake_date,
    output t_twq_sts    o_sts,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_task_id,
    output logic [31:0] o_out_wake_date,
    output logic [4:0]  o_entry_count,
    output logic        o_queue_empty
);
    logic [7:0]      r_ids   [Depth];
    logic [31:0]     r_dates [Depth];
    logic [CntW-1:0] r_occ;

    logic [2:0]      r_func;
    logic [7:0]      r_id;
    logic [31:0]     r_date;
    logic [Depth-1:0] r_ge;     // entry date >= new date
    logic [Depth-1:0] r_idm;    // entry id matches
    logic            r_tail_le; // tail date <= new date
    logic            r_done;

    // Per-cell compare, registered in the first cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_id   <= i_task_id;
            r_date <= i_wake_date;
            for (int k = 0; k < Depth; k++) begin
                r_ge[k]  <= r_dates[k] >= i_wake_date;
                r_idm[k] <= r_ids[k] == i_task_id;
            end
            r_tail_le <= (r_dates[IdxW'(r_occ - 1'b1)] <= i_wake_date);
        end
    end

    // Position decisions from the registered compare flags
    logic [Depth-1:0] v_valid, v_ins_after, v_rem_after, v_gehit, v_idhit;
    logic             full, empty, found, do_ins, do_rem, do_rot;
    logic [CntW-1:0]  ins_pos;
    logic [1:0]       n_status;

    always_comb begin
        for (int k = 0; k < Depth; k++) v_valid[k] = CntW'(k) < r_occ;
        v_gehit = r_ge & v_valid;
        v_idhit = r_idm & v_valid;
        full  = r_occ == CntW'(Depth);
        empty = r_occ == '0;
        found = |v_idhit;
        // insert position: first ge slot, else tail (sorted); tail (append)
        ins_pos = r_occ;
        if (r_func == FN_SORTED) begin
            for (int k = Depth - 1; k >= 0; k--) if (v_gehit[k]) ins_pos = CntW'(k);
            // not ahead of the head but at or past the tail: goes to the tail
            if (!v_gehit[0] && r_tail_le) ins_pos = r_occ;
        end
        // cells at or beyond the insert point shift up
        for (int k = 0; k < Depth; k++) v_ins_after[k] = CntW'(k) >= ins_pos;
        // cells at or beyond the removed point shift down
        v_rem_after[0] = (r_func == FN_REMOVE) ? v_idhit[0] : 1'b1;
        for (int k = 1; k < Depth; k++)
            v_rem_after[k] = v_rem_after[k-1] | ((r_func == FN_REMOVE) & v_idhit[k]);
        do_ins = 1'b0; do_rem = 1'b0; do_rot = 1'b0;
        n_status = ST_OK;
        unique case (r_func)
            FN_APPEND, FN_SORTED: if (full) n_status = ST_FULL; else do_ins = 1'b1;
            FN_POP:    if (empty) n_status = ST_EMPTY; else do_rem = 1'b1;
            FN_REMOVE: if (!found) n_status = ST_NOT_FOUND; else do_rem = 1'b1;
            FN_ROTATE: if (empty) n_status = ST_EMPTY; else do_rot = 1'b1;
            default: ;
        endcase
    end

    // Shift the cells and update occupancy
    logic [CntW-1:0] last;
    assign last = r_occ - 1'b1;
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int k = 0; k < Depth; k++) begin
                if (do_ins) begin
                    if (CntW'(k) == ins_pos) begin
                        r_ids[k] <= r_id; r_dates[k] <= r_date;
                    end else if (v_ins_after[k] && k > 0) begin
                        r_ids[k] <= r_ids[k-1]; r_dates[k] <= r_dates[k-1];
                    end
                end else if (do_rem || do_rot) begin
                    if (do_rot && CntW'(k) == last) begin
                        r_ids[k] <= r_ids[0]; r_dates[k] <= r_dates[0];
                    end else if (v_rem_after[k] && k < Depth - 1) begin
                        r_ids[k] <= r_ids[k+1]; r_dates[k] <= r_dates[k+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) begin
                if (do_ins)      r_occ <= r_occ + 1'b1;
                else if (do_rem) r_occ <= r_occ - 1'b1;
            end
        end
    end

    // Result register
    logic [CntW-1:0] n_occ;
    always_comb begin
        n_occ = r_occ;
        if (do_ins) n_occ = r_occ + 1'b1;
        else if (do_rem) n_occ = r_occ - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_status        <= n_status;
            o_out_task_id   <= (do_rem && r_func == FN_POP) ? r_ids[0] : 8'd0;
            o_out_wake_date <= (do_rem && r_func == FN_POP) ? r_dates[0] : 32'd0;
            o_entry_count   <= 5'(n_occ);
            o_queue_empty   <= n_occ == '0;
        end
    end

    assign o_done = r_done;
    assign o_sts.dummy_ready = 1'b1;
endmodule

/* rtl/task_wait_queue_unit.sv */
// Top level of the task wait queue unit
// An operation is taken at a rising edge with start high and busy low; the cell
// compares are registered at that edge, busy is then high for one cycle while
// the cells shift, and the result is on the o_ ports in the cycle after that under
// o_done. A new operation can be taken at the edge that ends the o_done cycle,
// so an operation is taken only once the previous result is out; the cell array
// compares and then shifts for each one. The receiver cannot stall: a result
// must be taken in its cycle.
`include "task_wait_queue_unit_defines.svh"
module task_wait_queue_unit import twq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_wake_date,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_task_id,
    output logic [31:0] o_out_wake_date,
    output logic [4:0]  o_entry_count,
    output logic        o_queue_empty
);
    t_twq_cmd cmd;
    t_twq_sts sts;

    twq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_sts(sts), .busy, .o_cmd(cmd)
    );

    twq_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_func, .i_task_id, .i_wake_date,
        .o_sts(sts), .o_done, .o_status, .o_out_task_id, .o_out_wake_date,
        .o_entry_count, .o_queue_empty
    );

    `TWQ_ASSERT_NEXT(a_done_after_exec, busy, o_done, "result missing after execute")
    `TWQ_ASSERT(a_empty_flag, !o_done || (o_queue_empty == (o_entry_count == 5'd0)),
        "empty flag disagrees with count")
    `TWQ_ASSERT(a_count_bound, !o_done || (o_entry_count <= 5'(Depth)), "count over depth")
endmodule

/* dv/task_wait_queue_unit_tb.sv */
// Testbench for the task wait queue unit: scoreboard with a queue model, directed and random ops
`timescale 1ns / 1ps

// Predicts each operation's result and checks the results the unit returns
class twq_scoreboard;
    logic [7:0]  ids [$];
    logic [31:0] dates [$];
    logic [1:0]  want_status [$];
    logic [7:0]  want_id [$];
    logic [31:0] want_date [$];
    logic [4:0]  want_count [$];
    logic        want_empty [$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // Apply one accepted operation to the queue and store the expected result
    function void note_op(logic [2:0] fn, logic [7:0] id, logic [31:0] date);
        logic [1:0]  st;
        logic [7:0]  pid;
        logic [31:0] pdate;
        int          k;
        st = twq_pkg::ST_OK;
        pid = '0;
        pdate = '0;
        case (fn)
            twq_pkg::FN_APPEND: begin
                if (ids.size() >= twq_pkg::Depth) begin
                    st = twq_pkg::ST_FULL;
                end else begin
                    ids.push_back(id);
                    dates.push_back(date);
                end
            end
            twq_pkg::FN_SORTED: begin
                if (ids.size() >= twq_pkg::Depth) begin
                    st = twq_pkg::ST_FULL;
                end else if (ids.size() == 0 || date <= dates[0]) begin
                    ids.push_front(id);
                    dates.push_front(date);
                end else if (date >= dates[$]) begin
                    ids.push_back(id);
                    dates.push_back(date);
                end else begin
                    k = 0;
                    while (k < dates.size() && date > dates[k]) k++;
                    ids.insert(k, id);
                    dates.insert(k, date);
                end
            end
            twq_pkg::FN_POP: begin
                if (ids.size() == 0) begin
                    st = twq_pkg::ST_EMPTY;
                end else begin
                    pid = ids.pop_front();
                    pdate = dates.pop_front();
                end
            end
            twq_pkg::FN_REMOVE: begin
                k = 0;
                while (k < ids.size() && ids[k] != id) k++;
                if (k < ids.size()) begin
                    ids.delete(k);
                    dates.delete(k);
                end else begin
                    st = twq_pkg::ST_NOT_FOUND;
                end
            end
            twq_pkg::FN_ROTATE: begin
                if (ids.size() == 0) begin
                    st = twq_pkg::ST_EMPTY;
                end else begin
                    ids.push_back(ids.pop_front());
                    dates.push_back(dates.pop_front());
                end
            end
            default: ;
        endcase
        want_status.push_back(st);
        want_id.push_back(pid);
        want_date.push_back(pdate);
        want_count.push_back(5'(ids.size()));
        want_empty.push_back(ids.size() == 0);
    endfunction

    // Compare one returned result with the oldest expectation
    function void check_result(logic [1:0] st, logic [7:0] id, logic [31:0] date,
                               logic [4:0] cnt, logic emp);
        if (want_status.size() == 0) begin
            $error("result with no operation pending");
            errors++;
            return;
        end
        if (st !== want_status[0]) begin
            $error("status exp %0d got %0d", want_status[0], st); errors++;
        end
        if (id !== want_id[0]) begin
            $error("out_task_id exp %0d got %0d", want_id[0], id); errors++;
        end
        if (date !== want_date[0]) begin
            $error("out_wake_date exp %0h got %0h", want_date[0], date); errors++;
        end
        if (cnt !== want_count[0]) begin
            $error("entry_count exp %0d got %0d", want_count[0], cnt); errors++;
        end
        if (emp !== want_empty[0]) begin
            $error("queue_empty exp %0d got %0d", want_empty[0], emp); errors++;
        end
        void'(want_status.pop_front());
        void'(want_id.pop_front());
        void'(want_date.pop_front());
        void'(want_count.pop_front());
        void'(want_empty.pop_front());
    endfunction

    function int pending();
        return want_status.size();
    endfunction
endclass

module task_wait_queue_unit_tb;
    import twq_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [7:0]  i_task_id;
    logic [31:0] i_wake_date;
    logic        o_done;
    logic [1:0]  o_status;
    logic [7:0]  o_out_task_id;
    logic [31:0] o_out_wake_date;
    logic [4:0]  o_entry_count;
    logic        o_queue_empty;

    twq_scoreboard queue_sb;
    int            cycle_count;
    logic [31:0]   recent_dates [$];

    task_wait_queue_unit u_top (.*);

    // Clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Result checking and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done)
            queue_sb.check_result(o_status, o_out_task_id, o_out_wake_date,
                                  o_entry_count, o_queue_empty);
        if (cycle_count > 200000) begin
            $display("task_wait_queue_unit verification failed");
            $finish;
        end
    end

    // One operation transfer, with a random gap ahead of it
    task automatic send_op(logic [2:0] fn, logic [7:0] id, logic [31:0] date);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        // busy only changes at the rising edge, so it is stable here
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_func <= fn;
        i_task_id <= id;
        i_wake_date <= date;
        @(posedge i_clk);
        queue_sb.note_op(fn, id, date);
        if (recent_dates.size() > 8) void'(recent_dates.pop_front());
        recent_dates.push_back(date);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Random date, often reusing a recent one to hit equal keys
    function automatic logic [31:0] pick_date();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return '0;
            2: return (recent_dates.size() > 0) ?
                      recent_dates[$urandom_range(0, recent_dates.size() - 1)] : '0;
            3: return 32'($urandom_range(0, 40));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 7));
        return 8'($urandom);
    endfunction

    initial begin
        int fill_target;
        logic [2:0] fn;
        queue_sb = new();
        cycle_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = '0;
        i_task_id = '0;
        i_wake_date = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty-queue cases, extremes, duplicates, undefined codes, fill to full
        send_op(FN_POP, 8'd0, 32'd0);
        send_op(FN_ROTATE, 8'd0, 32'd0);
        send_op(FN_REMOVE, 8'hFF, 32'd0);
        send_op(FN_SORTED, 8'hFF, 32'hFFFF_FFFF);
        send_op(FN_ROTATE, 8'd0, 32'd0);
        send_op(FN_SORTED, 8'd0, 32'd0);
        send_op(FN_SORTED, 8'h5A, 32'd100);
        send_op(FN_SORTED, 8'h5A, 32'd100);
        send_op(FN_SORTED, 8'hA5, 32'hFFFF_FFFF);
        send_op(FN_APPEND, 8'h11, 32'd7);
        send_op(FN_REMOVE, 8'h5A, 32'd0);
        send_op(3'd5, 8'hFF, 32'hFFFF_FFFF);
        send_op(3'd6, 8'd1, 32'd1);
        send_op(3'd7, 8'd2, 32'd2);
        for (int i = 0; i < 12; i++) send_op(FN_APPEND, 8'(i), 32'(i * 3));
        send_op(FN_SORTED, 8'h77, 32'd5);
        send_op(FN_APPEND, 8'h78, 32'd5);
        send_op(FN_ROTATE, 8'd0, 32'd0);
        send_op(FN_POP, 8'd0, 32'd0);
        send_op(FN_REMOVE, 8'hEE, 32'd0);

        // Random: sweep the fill level up and down, mostly valid ops
        for (int n = 0; n < 1450; n++) begin
            if (n % 60 == 0) fill_target = $urandom_range(0, Depth + 2);
            case ($urandom_range(0, 9))
                0, 1, 2: fn = (queue_sb.ids.size() < fill_target) ?
                              ($urandom_range(0, 2) == 0 ? FN_APPEND : FN_SORTED) : FN_POP;
                3: fn = FN_SORTED;
                4: fn = FN_APPEND;
                5: fn = FN_POP;
                6, 7: fn = FN_REMOVE;
                8: fn = FN_ROTATE;
                default: fn = 3'($urandom_range(0, 7));
            endcase
            if (fn == FN_REMOVE && queue_sb.ids.size() > 0 && $urandom_range(0, 2) != 0)
                send_op(fn, queue_sb.ids[$urandom_range(0, queue_sb.ids.size() - 1)],
                        $urandom);
            else
                send_op(fn, pick_id(), pick_date());
        end

        // Drain
        while (queue_sb.pending() > 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (queue_sb.errors == 0)
            $display("task_wait_queue_unit verification clean");
        else
            $display("task_wait_queue_unit verification failed");
        $finish;
    end
endmodule
